FILE: hdl/lbd_pkg.sv
package lbd_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WEFF_W       = COL_W + 1;
  localparam int IDX_W        = $clog2(LINE_DEPTH);
  localparam int CFG_W        = 13;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int PIX_W        = 8;
  localparam int PAIR_W       = PIX_W + 1;
  localparam int SUM_W        = PIX_W + 2;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] SRC_WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [0:0] {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [IDX_W-1:0]  idx;
    logic [PAIR_W-1:0] pair;
    logic              last;
  } pair_op_t;

endpackage

FILE: hdl/lbd_ram.sv
module lbd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/lbd_front.sv
module lbd_front
  import lbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] src_width,
  input  logic [CFG_W-1:0] src_height,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic             q_full,
  output logic             in_stall,
  output logic             push,
  output pair_op_t         push_op
);

  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [PIX_W-1:0]  held_pixel;
  logic [31:0]       w_raw, h_raw, w_clamp, h_clamp;
  logic [WEFF_W-1:0] w_eff, col_ext, col_plus, last_col;
  logic [ROW_W:0]    h_eff, row_ext, row_plus, last_row;
  logic              accept, active, odd_col;

  always_comb begin
    w_raw = 32'(src_width);
    h_raw = 32'(src_height);
    if (w_raw < 32'd2) begin
      w_clamp = 32'd2;
    end else if (w_raw > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = w_raw;
    end
    if (h_raw < 32'd2) begin
      h_clamp = 32'd2;
    end else if (h_raw > 32'(HEIGHT_LIMIT)) begin
      h_clamp = 32'(HEIGHT_LIMIT);
    end else begin
      h_clamp = h_raw;
    end
  end

  assign w_eff    = w_clamp[WEFF_W-1:0];
  assign h_eff    = h_clamp[ROW_W:0];
  assign col_ext  = {1'b0, column_count};
  assign row_ext  = {1'b0, row_count};
  assign col_plus = col_ext + WEFF_W'(1);
  assign row_plus = row_ext + (ROW_W+1)'(1);
  // last pair of the last complete row pair
  assign last_col = {w_eff[WEFF_W-1:1], 1'b0} - WEFF_W'(1);
  assign last_row = {h_eff[ROW_W:1], 1'b0} - (ROW_W+1)'(1);

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign active   = (col_ext < w_eff) && (row_ext < h_eff);
  assign odd_col  = column_count[0];
  assign push     = accept && active && odd_col;

  always_comb begin
    push_op.kind = row_count[0] ? OP_EMIT : OP_STORE;
    push_op.idx  = column_count[COL_W-1:1];
    push_op.pair = {1'b0, held_pixel} + {1'b0, pixel_in};
    push_op.last = (row_ext == last_row) && (col_ext == last_col);
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (col_plus >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (row_plus >= h_eff) ? '0 : row_plus[ROW_W-1:0];
    end else begin
      column_count_next = col_plus[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (active && !odd_col) begin
        held_pixel <= pixel_in;
      end
    end
  end

endmodule

FILE: hdl/lbd_queue.sv
module lbd_queue
  import lbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pair_op_t push_op,
  input  logic     pop,
  output logic     q_valid,
  output logic     q_full,
  output pair_op_t head
);

  pair_op_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_valid = (count != '0);
  assign q_full  = (count == (QPTR_W+1)'(QDEPTH));
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !q_valid))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: hdl/lbd_back.sv
module lbd_back
  import lbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pair_op_t         head,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_last
);

  logic              rd_valid, rd_last, rd_advance;
  logic [PAIR_W-1:0] rd_pair, ram_rdata;
  logic [SUM_W-1:0]  rd_sum;
  logic              pop_store, pop_emit;

  assign rd_advance = rd_valid && (!out_valid || !out_stall);
  assign pop        = q_valid && ((head.kind == OP_STORE) || !rd_valid || rd_advance);
  assign pop_store  = pop && (head.kind == OP_STORE);
  assign pop_emit   = pop && (head.kind == OP_EMIT);

  lbd_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (pop_store),
    .waddr(head.idx),
    .wdata(head.pair),
    .re   (pop_emit),
    .raddr(head.idx),
    .rdata(ram_rdata)
  );

  assign rd_sum = {1'b0, ram_rdata} + {1'b0, rd_pair};

  always_ff @(posedge clk) begin
    if (pop_emit) begin
      rd_pair <= head.pair;
      rd_last <= head.last;
    end
    if (rd_advance) begin
      pixel_out  <= rd_sum[SUM_W-1:2];
      frame_last <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop_emit) begin
        rd_valid <= 1'b1;
      end else if (rd_advance) begin
        rd_valid <= 1'b0;
      end
      if (rd_advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_reads: assert property (@(posedge clk) disable iff (rst)
    pop_emit |=> rd_valid)
    else $error("emit request lost after line read");

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && !rd_advance) |=> (rd_valid && $stable(rd_pair) && $stable(ram_rdata)))
    else $error("pending line read disturbed");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    rd_advance |=> out_valid)
    else $error("result dropped on way to output");
`endif

endmodule

FILE: hdl/luma_box_downsample_2x2_top.sv
// Luma 2x2 box downsampler: takes 8-bit pixels in raster order and returns one pixel per
// 2x2 block, floor of the block sum over four, with frame_last on the final result of the
// frame; an odd last row or column is dropped. It accepts one pixel every clock while in_stall is
// low, set by a single add in the front and one line-buffer access per pixel pair in the back; a
// small request queue between them absorbs output stalls, and a result passes through the queue,
// the line read and the output register. The line buffer is a 2048 x 9 RAM with no clearing pass,
// so the block is ready right after reset. Write src_width and src_height only while the block is
// idle.
module luma_box_downsample_2x2_top
  import lbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     pixel_out,
  output logic                 frame_last
);

  logic [CFG_W-1:0] src_width, src_height;
  logic             push, pop, q_valid, q_full;
  pair_op_t         push_op, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_WIDTH_RESET;
      src_height <= SRC_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_width (src_width),
    .src_height(src_height),
    .in_valid  (in_valid),
    .pixel_in  (pixel_in),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_op   (push_op)
  );

  lbd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .q_valid(q_valid),
    .q_full (q_full),
    .head   (head)
  );

  lbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .pixel_out (pixel_out),
    .frame_last(frame_last)
  );

endmodule

FILE: test/tb_luma_box_downsample_2x2_top.sv
module tb_luma_box_downsample_2x2_top;
  import lbd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int SETTLE       = 8;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } half_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     pixel_out;
  logic                 frame_last;

  luma_box_downsample_2x2_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // downsampler state as seen from outside
  logic [CFG_W-1:0]  reg_width = SRC_WIDTH_RESET;
  logic [CFG_W-1:0]  reg_height = SRC_HEIGHT_RESET;
  logic [PAIR_W-1:0] line_sum [LINE_DEPTH];
  logic [PIX_W-1:0]  held_px = '0;
  int unsigned       col_cnt = 0;
  int unsigned       row_cnt = 0;
  int unsigned       line_filled = 0;

  logic [PIX_W-1:0]  src_pixels [$];
  half_pixel_t       expected_pixels [$];
  half_pixel_t       want;
  bit                in_fired = 1'b0;
  bit                gaps_on = 1'b1;
  int                mismatch_count = 0;
  int                cycle_count = 0;

  function automatic int unsigned eff_width(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned eff_height(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return v;
  endfunction

  task automatic box_predict(input logic [PIX_W-1:0] px);
    int unsigned       w, h, c, r;
    logic [PAIR_W-1:0] pair;
    logic [SUM_W-1:0]  sum;
    half_pixel_t       res;
    w = eff_width(reg_width);
    h = eff_height(reg_height);
    c = col_cnt;
    r = row_cnt;
    if (c < w && r < h) begin
      if (c % 2 == 0) begin
        held_px = px;
      end else begin
        pair = PAIR_W'(held_px) + PAIR_W'(px);
        if (r % 2 == 0) begin
          line_sum[c / 2] = pair;
          if (c / 2 + 1 > line_filled) line_filled = c / 2 + 1;
        end else begin
          sum = SUM_W'(line_sum[c / 2]) + SUM_W'(pair);
          res.pix = sum[SUM_W-1:2];
          res.last = (r == (h & ~32'd1) - 1) && (c == (w & ~32'd1) - 1);
          expected_pixels.push_back(res);
        end
      end
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic queue_pixels(input int unsigned n);
    repeat (n) src_pixels.push_back(rand_pixel());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SRC_WIDTH) reg_width = val;
    else reg_height = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold until every request is taken and every result is back, then let the pipe empty
  task automatic wait_drained();
    while (src_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 15);
      if (!in_valid || in_fired) begin
        if (src_pixels.size() != 0 && !(gaps_on && $urandom_range(99) < 15)) begin
          in_valid <= 1'b1;
          pixel_in <= src_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      in_fired = !rst && in_valid && !in_stall;
      if (in_fired) box_predict(pixel_in);
      if (!rst && out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %0d with none expected", pixel_out));
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want.pix)
            report_mismatch($sformatf("pixel_out %0d, want %0d", pixel_out, want.pix));
          if (frame_last !== want.last)
            report_mismatch($sformatf("frame_last %0b, want %0b", frame_last, want.last));
        end
      end
    end
  end

  initial begin
    int unsigned      sent, n, w, h, pick;
    logic [CFG_W-1:0] new_w, new_h;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // both sizes below range clamp to a single 2x2 block
    write_reg(REG_SRC_WIDTH, 0);
    write_reg(REG_SRC_HEIGHT, 1);
    src_pixels = '{255, 255, 255, 255, 255, 255, 255, 254, 0, 0, 0, 3};
    wait_drained();

    // odd width and odd height: last column and last row drop out
    write_reg(REG_SRC_WIDTH, 3);
    write_reg(REG_SRC_HEIGHT, 3);
    src_pixels = '{10, 200, 99, 30, 255, 7, 1, 2, 3};
    wait_drained();

    // narrow the row under a pixel past the new width: it is dropped and ends the row
    write_reg(REG_SRC_WIDTH, 6);
    write_reg(REG_SRC_HEIGHT, 2);
    src_pixels = '{1, 2, 3, 4, 5};
    wait_drained();
    write_reg(REG_SRC_WIDTH, 4);
    src_pixels = '{77, 8, 9, 10, 11};
    wait_drained();

    // all-ones width clamps to the widest row; narrow it partway through the first row
    write_reg(REG_SRC_WIDTH, '1);
    write_reg(REG_SRC_HEIGHT, 2);
    queue_pixels(24);
    wait_drained();
    write_reg(REG_SRC_WIDTH, 24);
    queue_pixels(25);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      gaps_on = !(sent >= 350 && sent < 650);
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(7))
          0: new_w = CFG_W'($urandom_range(1));
          1: new_w = CFG_W'(2 * $urandom_range(1, 8) + 1);
          2: new_w = CFG_W'($urandom_range(60, 200));
          default: new_w = CFG_W'(2 * $urandom_range(1, 12));
        endcase
        case ($urandom_range(7))
          0: new_h = CFG_W'($urandom_range(1));
          1: new_h = '1;
          2: new_h = CFG_W'(2 * $urandom_range(1, 4) + 1);
          default: new_h = CFG_W'(2 * $urandom_range(1, 4));
        endcase
        // an odd row may only read line entries that some even row has filled
        if (row_cnt % 2 == 1 && eff_width(new_w) / 2 > line_filled)
          new_w = CFG_W'(2 * line_filled);
        pick = $urandom_range(2);
        // a row already past the height must finish before the height moves again
        if (row_cnt >= eff_height(reg_height)) pick = 1;
        if (pick != 2) write_reg(REG_SRC_WIDTH, new_w);
        if (pick != 1) write_reg(REG_SRC_HEIGHT, new_h);
      end
      w = eff_width(reg_width);
      h = eff_height(reg_height);
      if (w * h <= 400 && row_cnt < h && col_cnt < w && $urandom_range(3) != 0)
        n = (h - row_cnt) * w - col_cnt + w * h * $urandom_range(0, 2);
      else
        n = $urandom_range(1, 60);
      queue_pixels(n);
      sent += n;
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
